[design/psst_pkg.sv]
// Package for the periodic service slot timer.
// Holds the beat payload types, command and reply codes, and table control types.
`default_nettype none

package psst_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam int TAG_W    = 8;
    localparam int IVL_W    = 14;
    localparam int PERIOD_W = 16;

    // Input commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Reply kinds
    localparam logic [1:0] KIND_FIRE    = 2'd0;
    localparam logic [1:0] KIND_NO_FIRE = 2'd1;
    localparam logic [1:0] KIND_ADD     = 2'd2;
    localparam logic [1:0] KIND_REMOVE  = 2'd3;

    // Slot table operations
    localparam logic [1:0] TOP_NONE  = 2'd0;
    localparam logic [1:0] TOP_TICK  = 2'd1;
    localparam logic [1:0] TOP_CLAIM = 2'd2;
    localparam logic [1:0] TOP_FREE  = 2'd3;

    typedef struct packed {
        logic [1:0]       command;
        logic [TAG_W-1:0] tag;
        logic [IVL_W-1:0] interval;
    } t_in;

    typedef struct packed {
        logic [1:0]       reply_kind;
        logic [2:0]       slot;
        logic [TAG_W-1:0] fired_tag;
        logic             add_ok;
        logic [3:0]       removed_count;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [1:0]          op;
        logic [TAG_W-1:0]    tag;
        logic [PERIOD_W-1:0] period;
    } t_tbl_ctl;

    typedef struct packed {
        logic             valid;
        logic             tag_hit;
        logic             fire;
        logic [TAG_W-1:0] tag;
    } t_tbl_stat;

endpackage

`default_nettype wire

[design/psst_slot_table.sv]
// Slot table: valid bits, tag, period and counter per slot, plus the shared
// increment/compare unit that works on the slot chosen by i_idx. Uses psst_pkg.
`default_nettype none

module psst_slot_table #(
    parameter int SLOTS = psst_pkg::SLOTS_DEF,
    parameter int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [IDXW-1:0]       i_idx,
    input  psst_pkg::t_tbl_ctl    i_ctl,
    output psst_pkg::t_tbl_stat   o_stat
);
    import psst_pkg::*;

    logic [SLOTS-1:0]    r_valid;
    logic [TAG_W-1:0]    r_tag    [SLOTS];
    logic [PERIOD_W-1:0] r_period [SLOTS];
    logic [PERIOD_W-1:0] r_count  [SLOTS];

    logic [PERIOD_W-1:0] cnt_inc;
    logic                fire;

    // Shared unit: one increment and two compares on the selected slot
    always_comb begin
        cnt_inc = r_count[i_idx] + PERIOD_W'(1);
        fire    = r_valid[i_idx] && (cnt_inc == r_period[i_idx]);
    end

    assign o_stat.valid   = r_valid[i_idx];
    assign o_stat.tag_hit = r_valid[i_idx] && (r_tag[i_idx] == i_ctl.tag);
    assign o_stat.fire    = fire;
    assign o_stat.tag     = r_tag[i_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            unique case (i_ctl.op)
                TOP_CLAIM: r_valid[i_idx] <= 1'b1;
                TOP_FREE:  r_valid[i_idx] <= 1'b0;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            TOP_TICK: begin
                if (r_valid[i_idx]) begin
                    r_count[i_idx] <= fire ? '0 : cnt_inc;
                end
            end
            TOP_CLAIM: begin
                r_tag[i_idx]    <= i_ctl.tag;
                r_period[i_idx] <= i_ctl.period;
                r_count[i_idx]  <= '0;
            end
            TOP_FREE: begin
                r_tag[i_idx]    <= '0;
                r_period[i_idx] <= '0;
                r_count[i_idx]  <= '0;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[design/psst_seq.sv]
// Sequencer: takes one command beat, walks the slot table one slot a cycle unless
// a fire waits on a stalled output, and drives the result register. Uses psst_pkg.
`default_nettype none

module psst_seq #(
    parameter int SLOTS = psst_pkg::SLOTS_DEF,
    parameter int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  psst_pkg::t_in         i_in,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output psst_pkg::t_out        o_out,
    output logic [IDXW-1:0]       o_idx,
    output psst_pkg::t_tbl_ctl    o_ctl,
    input  psst_pkg::t_tbl_stat   i_stat
);
    import psst_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(SLOTS - 1);

    logic [1:0]        r_state, n_state;
    logic [IDXW-1:0]   r_idx, n_idx;
    logic [1:0]        r_cmd;
    logic [TAG_W-1:0]  r_tag;
    logic [IVL_W-1:0]  r_ivl;
    logic              r_found, n_found;
    logic [IDXW-1:0]   r_found_idx, n_found_idx;
    logic [3:0]        r_freed, n_freed;
    logic              r_pend_v, n_pend_v;
    logic [IDXW-1:0]   r_pend_idx, n_pend_idx;
    logic [TAG_W-1:0]  r_pend_tag, n_pend_tag;
    logic [NRES_W-1:0] r_nres, n_nres;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic out_free;
    logic in_acc;
    logic step;

    assign out_free    = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_idx       = r_idx;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_freed     = r_freed;
        n_pend_v    = r_pend_v;
        n_pend_idx  = r_pend_idx;
        n_pend_tag  = r_pend_tag;
        n_nres      = r_nres;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        step        = 1'b1;
        o_ctl.op     = TOP_NONE;
        o_ctl.tag    = r_tag;
        o_ctl.period = {r_ivl, 2'b00};

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_freed    = '0;
                    n_pend_v   = 1'b0;
                    n_nres     = '0;
                    // unknown command: drop without a result
                    n_state    = (i_in.command == CMD_TICK || i_in.command == CMD_ADD ||
                                  i_in.command == CMD_REMOVE) ? ST_WALK : ST_IDLE;
                end
            end
            ST_WALK: begin
                unique case (r_cmd)
                    CMD_TICK: begin
                        if (i_stat.fire && r_nres < NRES_W'(MAX_RESULTS)) begin
                            if (r_pend_v && !out_free) begin
                                step = 1'b0; // hold until the earlier fire beat drains
                            end else begin
                                if (r_pend_v) begin
                                    n_out_valid         = 1'b1;
                                    n_out               = '0;
                                    n_out.reply_kind    = KIND_FIRE;
                                    n_out.slot          = 3'(r_pend_idx);
                                    n_out.fired_tag     = r_pend_tag;
                                end
                                n_pend_v   = 1'b1;
                                n_pend_idx = r_idx;
                                n_pend_tag = i_stat.tag;
                                n_nres     = r_nres + NRES_W'(1);
                            end
                        end
                        if (step) o_ctl.op = TOP_TICK;
                    end
                    CMD_ADD: begin
                        if (!r_found && !i_stat.valid) begin
                            o_ctl.op    = TOP_CLAIM;
                            n_found     = 1'b1;
                            n_found_idx = r_idx;
                        end
                    end
                    default: begin
                        if (i_stat.tag_hit) begin
                            o_ctl.op = TOP_FREE;
                            if (r_freed != 4'hF) n_freed = r_freed + 4'd1;
                        end
                    end
                endcase
                if (step) begin
                    if (r_idx == IDX_LAST) n_state = ST_DONE;
                    else                   n_idx   = r_idx + IDXW'(1);
                end
            end
            default: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    unique case (r_cmd)
                        CMD_TICK: begin
                            if (r_pend_v) begin
                                n_out.reply_kind = KIND_FIRE;
                                n_out.slot       = 3'(r_pend_idx);
                                n_out.fired_tag  = r_pend_tag;
                            end else begin
                                n_out.reply_kind = KIND_NO_FIRE;
                            end
                        end
                        CMD_ADD: begin
                            n_out.reply_kind = KIND_ADD;
                            n_out.add_ok     = r_found;
                            n_out.slot       = r_found ? 3'(r_found_idx) : 3'd0;
                        end
                        default: begin
                            n_out.reply_kind    = KIND_REMOVE;
                            n_out.removed_count = r_freed;
                        end
                    endcase
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_in.command;
            r_tag <= i_in.tag;
            r_ivl <= i_in.interval;
        end
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_found_idx <= n_found_idx;
        r_freed     <= n_freed;
        r_pend_v    <= n_pend_v;
        r_pend_idx  <= n_pend_idx;
        r_pend_tag  <= n_pend_tag;
        r_nres      <= n_nres;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire

[design/periodic_service_slot_timer.sv]
// Periodic service slot timer, top level.
// Each command beat walks the slot table one slot a cycle through one shared
// increment/compare unit, unless a stalled output holds a tick walk; the last
// result is registered once the walk is done and the output is free, and a new
// beat is taken only after that, when the sequencer is back in idle.
// Synchronous active-low reset frees every slot and drops any pending result.
`default_nettype none

module periodic_service_slot_timer #(
    parameter int SLOTS = psst_pkg::SLOTS_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  psst_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output psst_pkg::t_out  o_out
);
    import psst_pkg::*;

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [IDXW-1:0] idx;
    t_tbl_ctl        ctl;
    t_tbl_stat       stat;

    psst_seq #(
        .SLOTS (SLOTS),
        .IDXW  (IDXW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_idx       (idx),
        .o_ctl       (ctl),
        .i_stat      (stat)
    );

    psst_slot_table #(
        .SLOTS (SLOTS),
        .IDXW  (IDXW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (idx),
        .i_ctl   (ctl),
        .o_stat  (stat)
    );

endmodule

`default_nettype wire

[tb/periodic_service_slot_timer_tb.sv]
// Testbench for periodic_service_slot_timer: directed and random command beats,
// with the expected replies worked out by a slot-table predictor held here.
// Depends on psst_pkg and the top level of the block only.
`default_nettype none

module periodic_service_slot_timer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psst_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CAP = 4000;
    localparam int SETTLE = 4 * (NSLOT + 2);
    localparam int IDLE_PCT = 18;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    // Predicted slot table
    logic        armed [NSLOT];
    logic [7:0]  svc_tag [NSLOT];
    logic [15:0] svc_period [NSLOT];
    logic [15:0] svc_count [NSLOT];

    t_out due_replies[$];
    int   errors = 0;
    bit   steady = 1'b0;
    logic [7:0] tag_pool [4] = '{8'h11, 8'h22, 8'h33, 8'hC4};

    periodic_service_slot_timer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Work out the replies caused by one accepted command beat
    task automatic forecast_replies(input t_in cmd);
        t_out burst[$];
        t_out r;
        int   freed;
        int   claim;
        freed = 0;
        claim = -1;
        case (cmd.command)
            CMD_TICK: begin
                for (int s = 0; s < NSLOT; s++) begin
                    if (armed[s]) begin
                        svc_count[s] = svc_count[s] + 16'd1;
                        if (svc_count[s] == svc_period[s]) begin
                            svc_count[s] = '0;
                            if (burst.size() < MAX_RESULTS) begin
                                r = '0;
                                r.reply_kind = KIND_FIRE;
                                r.slot = 3'(s);
                                r.fired_tag = svc_tag[s];
                                burst.push_back(r);
                            end
                        end
                    end
                end
                if (burst.size() == 0) begin
                    r = '0;
                    r.reply_kind = KIND_NO_FIRE;
                    burst.push_back(r);
                end
            end
            CMD_ADD: begin
                for (int s = NSLOT - 1; s >= 0; s--) begin
                    if (!armed[s]) claim = s;
                end
                r = '0;
                r.reply_kind = KIND_ADD;
                if (claim >= 0) begin
                    armed[claim] = 1'b1;
                    svc_tag[claim] = cmd.tag;
                    svc_period[claim] = {cmd.interval, 2'b00};
                    svc_count[claim] = '0;
                    r.slot = 3'(claim);
                    r.add_ok = 1'b1;
                end
                burst.push_back(r);
            end
            CMD_REMOVE: begin
                for (int s = 0; s < NSLOT; s++) begin
                    if (armed[s] && svc_tag[s] == cmd.tag) begin
                        armed[s] = 1'b0;
                        svc_tag[s] = '0;
                        svc_period[s] = '0;
                        svc_count[s] = '0;
                        freed++;
                    end
                end
                r = '0;
                r.reply_kind = KIND_REMOVE;
                r.removed_count = (freed > 15) ? 4'd15 : 4'(freed);
                burst.push_back(r);
            end
            default: ;
        endcase
        if (burst.size() > 0) begin
            r = burst.pop_back();
            r.last = 1'b1;
            burst.push_back(r);
        end
        foreach (burst[k]) due_replies.push_back(burst[k]);
    endtask

    task automatic send_beat(input logic [1:0] command, input logic [7:0] tag,
                             input logic [13:0] interval);
        t_in cmd;
        cmd.command = command;
        cmd.tag = tag;
        cmd.interval = interval;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_valid <= 1'b1;
        i_in <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        forecast_replies(cmd);
    endtask

    // Drop valid and wait until every predicted reply has come back or DRAIN_CAP is reached
    task automatic drain();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (due_replies.size() != 0 && waited < DRAIN_CAP) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_replies.size() == 0) begin
                $display("%0t: reply with none expected, actual %0h", $time, o_out);
                errors++;
            end else begin
                want = due_replies.pop_front();
                check_field("reply_kind", 8'(want.reply_kind), 8'(o_out.reply_kind));
                check_field("slot", 8'(want.slot), 8'(o_out.slot));
                check_field("fired_tag", want.fired_tag, o_out.fired_tag);
                check_field("add_ok", 8'(want.add_ok), 8'(o_out.add_ok));
                check_field("removed_count", 8'(want.removed_count),
                            8'(o_out.removed_count));
                check_field("last", 8'(want.last), 8'(o_out.last));
            end
        end
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Unused command, remove and tick on an empty table
    task automatic test_empty_table();
        send_beat(CMD_UNUSED, 8'hFF, 14'h3FFF);
        send_beat(CMD_REMOVE, 8'h00, 14'h0000);
        send_beat(CMD_TICK, 8'h00, 14'h0000);
        drain();
    endtask

    // Fill every slot, including zero and largest interval, then overflow
    task automatic test_fill_table();
        send_beat(CMD_ADD, 8'hFF, 14'h0000);
        send_beat(CMD_ADD, 8'h00, 14'h3FFF);
        repeat (NSLOT - 2) send_beat(CMD_ADD, 8'h5A, 14'd1);
        send_beat(CMD_ADD, 8'hA5, 14'h2AAA);
        drain();
    endtask

    task automatic test_periodic_fire();
        repeat (4) send_beat(CMD_TICK, 8'h00, 14'h0000);
        drain();
    endtask

    // Swap the two slow slots for fast ones so that every slot fires at once
    task automatic test_all_slots_fire();
        send_beat(CMD_REMOVE, 8'hFF, 14'h0000);
        send_beat(CMD_REMOVE, 8'h00, 14'h0000);
        send_beat(CMD_ADD, 8'h3C, 14'd1);
        send_beat(CMD_ADD, 8'hC3, 14'd1);
        repeat (4) send_beat(CMD_TICK, 8'h00, 14'h0000);
        drain();
    endtask

    task automatic test_remove_many();
        send_beat(CMD_REMOVE, 8'h5A, 14'h1555);
        send_beat(CMD_REMOVE, 8'h77, 14'h0000);
        drain();
    endtask

    task automatic test_random_traffic(input int beats);
        int roll;
        logic [1:0]  command;
        logic [7:0]  tag;
        logic [13:0] interval;
        for (int k = 0; k < beats; k++) begin
            steady = (k >= 40 && k < 75);
            roll = $urandom_range(99);
            if (roll < 50) command = CMD_TICK;
            else if (roll < 75) command = CMD_ADD;
            else if (roll < 93) command = CMD_REMOVE;
            else command = CMD_UNUSED;
            tag = ($urandom_range(99) < 80) ? tag_pool[$urandom_range(3)]
                                            : 8'($urandom_range(255));
            roll = $urandom_range(99);
            if (roll < 70) interval = 14'($urandom_range(3, 1));
            else if (roll < 85) interval = '0;
            else interval = 14'($urandom_range(16383));
            send_beat(command, tag, interval);
        end
        steady = 1'b0;
        drain();
    endtask

    initial begin
        for (int s = 0; s < NSLOT; s++) begin
            armed[s] = 1'b0;
            svc_tag[s] = '0;
            svc_period[s] = '0;
            svc_count[s] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_fill_table();
        test_periodic_fire();
        test_all_slots_fire();
        test_remove_many();
        test_random_traffic(84);
        repeat (SETTLE) @(posedge i_clk);
        if (due_replies.size() != 0) begin
            $display("%0t: %0d replies never arrived, next expected %0h",
                     $time, due_replies.size(), due_replies[0]);
            errors++;
        end
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/psst_pkg.sv
design/psst_slot_table.sv
design/psst_seq.sv
design/periodic_service_slot_timer.sv
tb/periodic_service_slot_timer_tb.sv
